// File: rtl/art_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg
// Types and constants shared by the retransmission table and its channels.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int SLOTS       = 16;
	localparam int AW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MAX_RESULTS = 16;
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	localparam logic [15:0] HDR_BYTES       = 16'd7;
	localparam logic [15:0] RST_MAX_FRAME   = 16'd1472;
	localparam logic [15:0] RST_TIMEOUT     = 16'd200;
	localparam logic [7:0]  RST_MAX_RESENDS = 8'd5;

	typedef enum logic [1:0] {
		ACT_SEND = 2'd0,
		ACT_RECV = 2'd1,
		ACT_SCAN = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_SENT      = 3'd0,
		STS_UNTRACKED = 3'd1,
		STS_LINK_DOWN = 3'd2,
		STS_TOO_LONG  = 3'd3,
		STS_RECEIVED  = 3'd4,
		STS_DROPPED   = 3'd5,
		STS_RESEND    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_LINK_UP     = 2'd0,
		REG_MAX_FRAME   = 2'd1,
		REG_TIMEOUT     = 2'd2,
		REG_MAX_RESENDS = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RECV,
		SQ_SCAN
	} seq_state_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [7:0]  ftype;
		logic [15:0] flen;
		logic [31:0] stime;
		logic [7:0]  resends;
	} slot_entry_t;

endpackage
`default_nettype wire

// File: rtl/art_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_if
// Command, result and register-write channels of the retransmission table.
// ----------------------------------------------------------------------------
interface art_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] now_ms;
	logic [7:0]  ptype;
	logic [15:0] body_len;
	logic [15:0] received_len;
	logic [15:0] header_total_len;
	logic [31:0] header_seq;
	modport source (output valid, action, now_ms, ptype, body_len,
		received_len, header_total_len, header_seq, input ready);
	modport sink (input valid, action, now_ms, ptype, body_len,
		received_len, header_total_len, header_seq, output ready);
endinterface

interface art_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] seq_number;
	logic [7:0]  frame_type;
	logic [15:0] length;
	logic [7:0]  slot_index;
	logic        last;
	modport source (output valid, status, seq_number, frame_type, length,
		slot_index, last, input ready);
	modport sink (input valid, status, seq_number, frame_type, length,
		slot_index, last, output ready);
endinterface

interface art_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/ack_retransmit_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ack_retransmit_table
// Tracks unacknowledged frames in a slot memory; sends, acknowledges, resends.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  cmd      in   valid/ready   action, time, frame header fields
//  res      out  valid/ready   status, sequence, type, length, slot, last
//  cfg      in   valid/ready   register index, write data
//
//  Send and refused items: result registered the next cycle.
//  Receive: one slot memory read per cycle.
//  Scan: the memory read port visits one slot a cycle, and a found resend
//  waits while the result register is full.
//  Reset clears control state and valid bits; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module ack_retransmit_table (
	input  wire logic     clk,
	input  wire logic     arst_n,
	art_cmd_if.sink       cmd,
	art_res_if.source     res,
	art_cfg_if.sink       cfg
);

	localparam int AW = art_pkg::AW;
	localparam int NW = art_pkg::NW;

	art_pkg::slot_entry_t mem [art_pkg::SLOTS];

	art_pkg::seq_state_t state_q, state_d;

	logic                    link_q;
	logic [15:0]             max_frame_q;
	logic [15:0]             timeout_q;
	logic [7:0]              max_res_q;
	logic [31:0]             nseq_q;
	logic [art_pkg::SLOTS-1:0] valid_q;

	logic [31:0] now_q;
	logic [7:0]  pid_q;
	logic [31:0] hseq_q;
	logic [15:0] rlen_q;
	logic        found_q;
	logic [NW-1:0] n_q;
	logic [AW:0] cnt_q;

	logic        v_s1;
	logic [AW-1:0] idx_s1;
	art_pkg::slot_entry_t rd_s1;

	logic        pend_q;
	logic [31:0] pend_seq_q;
	logic [7:0]  pend_type_q;
	logic [15:0] pend_len_q;
	logic [7:0]  pend_slot_q;

	logic        ov_q;
	logic [2:0]  o_sts_q;
	logic [31:0] o_seq_q;
	logic [7:0]  o_type_q;
	logic [15:0] o_len_q;
	logic [7:0]  o_slot_q;
	logic        o_last_q;

	logic        out_free, accept, free_hit, too_long, bad_rx;
	logic [AW-1:0] free_idx;
	logic [16:0] flen;
	logic [31:0] age;
	logic        hit, timed, drop, emit, match, stall, adv, issue, done;
	logic        ld;
	logic [2:0]  ld_sts;
	logic [31:0] ld_seq;
	logic [7:0]  ld_type;
	logic [15:0] ld_len;
	logic [7:0]  ld_slot;
	logic        ld_last;
	logic        wr_en;
	logic [AW-1:0] wr_idx;
	art_pkg::slot_entry_t wr_data;

	assign cfg.ready = 1'b1;

	assign res.valid      = ov_q;
	assign res.status     = o_sts_q;
	assign res.seq_number = o_seq_q;
	assign res.frame_type = o_type_q;
	assign res.length     = o_len_q;
	assign res.slot_index = o_slot_q;
	assign res.last       = o_last_q;

	assign out_free  = !ov_q || res.ready;
	assign cmd.ready = (state_q == art_pkg::SQ_IDLE) && out_free;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = art_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_hit = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	assign flen     = {1'b0, cmd.body_len} + {1'b0, art_pkg::HDR_BYTES};
	assign too_long = flen > {1'b0, max_frame_q};
	assign bad_rx   = (cmd.received_len < art_pkg::HDR_BYTES)
		|| (cmd.header_total_len < art_pkg::HDR_BYTES)
		|| (cmd.header_total_len > cmd.received_len);

	assign age   = now_q - rd_s1.stime;
	assign hit   = v_s1 && valid_q[idx_s1];
	assign timed = age >= {16'd0, timeout_q};
	assign drop  = (state_q == art_pkg::SQ_SCAN) && hit && timed
		&& (rd_s1.resends >= max_res_q);
	assign emit  = (state_q == art_pkg::SQ_SCAN) && hit && timed && !drop
		&& (n_q < NW'(art_pkg::MAX_RESULTS));
	assign match = (state_q == art_pkg::SQ_RECV) && hit && !found_q
		&& (rd_s1.seq == hseq_q);
	assign stall = emit && pend_q && !out_free;
	assign adv   = !stall;
	assign issue = (state_q != art_pkg::SQ_IDLE) && adv
		&& (cnt_q < (AW+1)'(art_pkg::SLOTS));
	assign done  = (cnt_q == (AW+1)'(art_pkg::SLOTS)) && !v_s1;

	always_comb begin
		state_d = state_q;
		ld      = 1'b0;
		ld_sts  = art_pkg::STS_SENT;
		ld_seq  = '0;
		ld_type = cmd.ptype;
		ld_len  = '0;
		ld_slot = '0;
		ld_last = 1'b1;
		wr_en   = 1'b0;
		wr_idx  = free_idx;
		wr_data.seq     = nseq_q;
		wr_data.ftype   = cmd.ptype;
		wr_data.flen    = flen[15:0];
		wr_data.stime   = cmd.now_ms;
		wr_data.resends = '0;
		unique case (state_q)
			art_pkg::SQ_IDLE: begin
				if (accept) begin
					unique case (art_pkg::action_t'(cmd.action))
						art_pkg::ACT_SEND: begin
							ld = 1'b1;
							if (!link_q) begin
								ld_sts = art_pkg::STS_LINK_DOWN;
							end else if (too_long) begin
								ld_sts = art_pkg::STS_TOO_LONG;
							end else begin
								ld_seq = nseq_q;
								ld_len = flen[15:0];
								if (free_hit) begin
									ld_sts  = art_pkg::STS_SENT;
									ld_slot = 8'(free_idx);
									wr_en   = 1'b1;
								end else begin
									ld_sts = art_pkg::STS_UNTRACKED;
								end
							end
						end
						art_pkg::ACT_RECV: begin
							if (!link_q) begin
								ld     = 1'b1;
								ld_sts = art_pkg::STS_LINK_DOWN;
							end else if (bad_rx) begin
								ld     = 1'b1;
								ld_sts = art_pkg::STS_DROPPED;
							end else begin
								state_d = art_pkg::SQ_RECV;
							end
						end
						art_pkg::ACT_SCAN: state_d = art_pkg::SQ_SCAN;
						art_pkg::ACT_NONE: ;
						default: ;
					endcase
				end
			end
			art_pkg::SQ_RECV: begin
				if (done && out_free) begin
					ld      = 1'b1;
					ld_sts  = art_pkg::STS_RECEIVED;
					ld_seq  = hseq_q;
					ld_type = pid_q;
					ld_len  = rlen_q;
					state_d = art_pkg::SQ_IDLE;
				end
			end
			art_pkg::SQ_SCAN: begin
				wr_idx          = idx_s1;
				wr_data         = rd_s1;
				wr_data.stime   = now_q;
				wr_data.resends = rd_s1.resends + 8'd1;
				wr_en           = emit && adv;
				ld_sts  = art_pkg::STS_RESEND;
				ld_seq  = pend_seq_q;
				ld_type = pend_type_q;
				ld_len  = pend_len_q;
				ld_slot = pend_slot_q;
				if (emit && pend_q && adv) begin
					ld      = 1'b1;
					ld_last = 1'b0;
				end else if (done) begin
					if (!pend_q) begin
						state_d = art_pkg::SQ_IDLE;
					end else if (out_free) begin
						ld      = 1'b1;
						state_d = art_pkg::SQ_IDLE;
					end
				end
			end
			default: state_d = art_pkg::SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (issue) begin
			rd_s1  <= mem[cnt_q[AW-1:0]];
			idx_s1 <= cnt_q[AW-1:0];
		end
		if (accept) begin
			now_q  <= cmd.now_ms;
			pid_q  <= cmd.ptype;
			hseq_q <= cmd.header_seq;
			rlen_q <= cmd.header_total_len - art_pkg::HDR_BYTES;
		end
		if (emit && adv) begin
			pend_seq_q  <= rd_s1.seq;
			pend_type_q <= rd_s1.ftype;
			pend_len_q  <= rd_s1.flen;
			pend_slot_q <= 8'(idx_s1);
		end
		if (ld) begin
			o_sts_q  <= ld_sts;
			o_seq_q  <= ld_seq;
			o_type_q <= ld_type;
			o_len_q  <= ld_len;
			o_slot_q <= ld_slot;
			o_last_q <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= art_pkg::SQ_IDLE;
			link_q      <= 1'b0;
			max_frame_q <= art_pkg::RST_MAX_FRAME;
			timeout_q   <= art_pkg::RST_TIMEOUT;
			max_res_q   <= art_pkg::RST_MAX_RESENDS;
			nseq_q      <= '0;
			valid_q     <= '0;
			found_q     <= 1'b0;
			n_q         <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			pend_q      <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				unique case (art_pkg::reg_idx_t'(cfg.index))
					art_pkg::REG_LINK_UP:     link_q      <= cfg.data[0];
					art_pkg::REG_MAX_FRAME:   max_frame_q <= cfg.data;
					art_pkg::REG_TIMEOUT:     timeout_q   <= cfg.data;
					art_pkg::REG_MAX_RESENDS: max_res_q   <= cfg.data[7:0];
					default: ;
				endcase
			end
			if (accept && art_pkg::action_t'(cmd.action) == art_pkg::ACT_SEND
					&& link_q && !too_long) begin
				nseq_q <= nseq_q + 32'd1;
			end
			if (wr_en && state_q == art_pkg::SQ_IDLE) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (match || drop) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (accept) begin
				found_q <= 1'b0;
				n_q     <= '0;
				cnt_q   <= '0;
				pend_q  <= 1'b0;
			end else begin
				if (match) begin
					found_q <= 1'b1;
				end
				if (issue) begin
					cnt_q <= cnt_q + (AW+1)'(1);
				end
				if (emit && adv) begin
					n_q    <= n_q + NW'(1);
					pend_q <= 1'b1;
				end else if (ld && state_q == art_pkg::SQ_SCAN) begin
					pend_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s1 <= issue;
			end
			if (ld) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/art_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_chk
// Port-level checks on the retransmission table, bound into the table module.
// ----------------------------------------------------------------------------
module art_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [2:0]  res_status,
	input wire logic [31:0] res_seq_number,
	input wire logic [15:0] res_length,
	input wire logic [7:0]  res_slot_index,
	input wire logic        res_last
);

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |-> (!res_valid || res_ready))
		else $error("command taken while result register is blocked");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status != art_pkg::STS_RESEND) |-> res_last)
		else $error("non-resend result without last");

	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_status == art_pkg::STS_LINK_DOWN
			|| res_status == art_pkg::STS_TOO_LONG
			|| res_status == art_pkg::STS_DROPPED))
		|-> (res_seq_number == 32'd0 && res_length == 16'd0
			&& res_slot_index == 8'd0))
		else $error("refusal carries data");

	a_sent_seq_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && (res_status == art_pkg::STS_SENT
			|| res_status == art_pkg::STS_UNTRACKED)) ##1
		(res_valid && (res_status == art_pkg::STS_SENT
			|| res_status == art_pkg::STS_UNTRACKED))
		|-> res_seq_number == $past(res_seq_number) + 32'd1)
		else $error("sequence numbers of consecutive sends not consecutive");

endmodule

bind ack_retransmit_table art_chk u_art_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_status     (res.status),
	.res_seq_number (res.seq_number),
	.res_length     (res.length),
	.res_slot_index (res.slot_index),
	.res_last       (res.last)
);
`default_nettype wire

// File: test/art_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_checker
// Watches the command, result and register channels of the retransmission
// table, keeps a shadow of its slot table and checks every result word.
// ----------------------------------------------------------------------------
module art_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	art_cmd_if.sink   cmd,
	art_res_if.sink   res,
	art_cfg_if.sink   cfg,
	output int        fail_count,
	output int        pending
);

	typedef struct packed {
		art_pkg::status_t status;
		logic [31:0]      seq;
		logic [7:0]       ftype;
		logic [15:0]      flen;
		logic [7:0]       slot;
		logic             last;
	} art_word_t;

	logic                 sh_link_up;
	logic [15:0]          sh_max_frame;
	logic [15:0]          sh_timeout;
	logic [7:0]           sh_max_resends;
	logic [31:0]          sh_next_seq;
	logic                 sh_valid [art_pkg::SLOTS];
	art_pkg::slot_entry_t sh_slot  [art_pkg::SLOTS];
	art_word_t            awaited [$];

	assign pending = awaited.size();

	task automatic push_word(art_pkg::status_t s, logic [31:0] q, logic [7:0] t,
		logic [15:0] l, logic [7:0] sl, logic lst);
		art_word_t w;
		w.status = s; w.seq = q; w.ftype = t; w.flen = l; w.slot = sl; w.last = lst;
		awaited.push_back(w);
	endtask

	task automatic track_command();
		logic [15:0] flen;
		logic [31:0] age;
		int          n;
		int          first_q;
		bit          placed;
		bit          hit;
		flen = cmd.body_len + art_pkg::HDR_BYTES;
		case (art_pkg::action_t'(cmd.action))
		art_pkg::ACT_SEND: begin
			if (!sh_link_up)
				push_word(art_pkg::STS_LINK_DOWN, 32'd0, cmd.ptype, 16'd0, 8'd0, 1'b1);
			else if ({16'd0, cmd.body_len} + 32'd7 > {16'd0, sh_max_frame})
				push_word(art_pkg::STS_TOO_LONG, 32'd0, cmd.ptype, 16'd0, 8'd0, 1'b1);
			else begin
				placed = 0;
				for (int i = 0; i < art_pkg::SLOTS; i++) begin
					if (!placed && !sh_valid[i]) begin
						placed = 1;
						sh_valid[i] = 1;
						sh_slot[i] = '{sh_next_seq, cmd.ptype, flen, cmd.now_ms, 8'd0};
						push_word(art_pkg::STS_SENT, sh_next_seq, cmd.ptype, flen,
							8'(i), 1'b1);
					end
				end
				if (!placed)
					push_word(art_pkg::STS_UNTRACKED, sh_next_seq, cmd.ptype, flen,
						8'd0, 1'b1);
				sh_next_seq = sh_next_seq + 32'd1;
			end
		end
		art_pkg::ACT_RECV: begin
			if (!sh_link_up)
				push_word(art_pkg::STS_LINK_DOWN, 32'd0, cmd.ptype, 16'd0, 8'd0, 1'b1);
			else if (cmd.received_len < art_pkg::HDR_BYTES
					|| cmd.header_total_len < art_pkg::HDR_BYTES
					|| cmd.header_total_len > cmd.received_len)
				push_word(art_pkg::STS_DROPPED, 32'd0, cmd.ptype, 16'd0, 8'd0, 1'b1);
			else begin
				hit = 0;
				for (int i = 0; i < art_pkg::SLOTS; i++) begin
					if (!hit && sh_valid[i] && sh_slot[i].seq == cmd.header_seq) begin
						hit = 1;
						sh_valid[i] = 0;
					end
				end
				push_word(art_pkg::STS_RECEIVED, cmd.header_seq, cmd.ptype,
					cmd.header_total_len - art_pkg::HDR_BYTES, 8'd0, 1'b1);
			end
		end
		art_pkg::ACT_SCAN: begin
			n = 0;
			first_q = awaited.size();
			for (int i = 0; i < art_pkg::SLOTS; i++) begin
				if (sh_valid[i]) begin
					age = cmd.now_ms - sh_slot[i].stime;
					if (age >= {16'd0, sh_timeout}) begin
						if (sh_slot[i].resends >= sh_max_resends)
							sh_valid[i] = 0;
						else if (n < art_pkg::MAX_RESULTS) begin
							push_word(art_pkg::STS_RESEND, sh_slot[i].seq, sh_slot[i].ftype,
								sh_slot[i].flen, 8'(i), 1'b0);
							n++;
							sh_slot[i].stime = cmd.now_ms;
							sh_slot[i].resends = sh_slot[i].resends + 8'd1;
						end
					end
				end
			end
			if (n > 0)
				awaited[first_q + n - 1].last = 1;
		end
		default: ;
		endcase
	endtask

	task automatic check_word();
		art_word_t w;
		if (awaited.size() == 0) begin
			$error("unexpected result word status=%0d seq=%0d", res.status, res.seq_number);
			fail_count++;
			return;
		end
		w = awaited.pop_front();
		if (res.status !== w.status) begin
			$error("status: expected %0d, got %0d", w.status, res.status); fail_count++;
		end
		if (res.seq_number !== w.seq) begin
			$error("seq_number: expected %0d, got %0d", w.seq, res.seq_number); fail_count++;
		end
		if (res.frame_type !== w.ftype) begin
			$error("frame_type: expected %0d, got %0d", w.ftype, res.frame_type); fail_count++;
		end
		if (res.length !== w.flen) begin
			$error("length: expected %0d, got %0d", w.flen, res.length); fail_count++;
		end
		if (res.slot_index !== w.slot) begin
			$error("slot_index: expected %0d, got %0d", w.slot, res.slot_index); fail_count++;
		end
		if (res.last !== w.last) begin
			$error("last: expected %0d, got %0d", w.last, res.last); fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_link_up     = 0;
			sh_max_frame   = art_pkg::RST_MAX_FRAME;
			sh_timeout     = art_pkg::RST_TIMEOUT;
			sh_max_resends = art_pkg::RST_MAX_RESENDS;
			sh_next_seq    = 0;
			for (int i = 0; i < art_pkg::SLOTS; i++) sh_valid[i] = 0;
			awaited.delete();
			fail_count = 0;
		end else begin
			if (res.valid && res.ready)
				check_word();
			if (cfg.valid && cfg.ready) begin
				case (art_pkg::reg_idx_t'(cfg.index))
				art_pkg::REG_LINK_UP:     sh_link_up = cfg.data[0];
				art_pkg::REG_MAX_FRAME:   sh_max_frame = cfg.data;
				art_pkg::REG_TIMEOUT:     sh_timeout = cfg.data;
				art_pkg::REG_MAX_RESENDS: sh_max_resends = cfg.data[7:0];
				endcase
			end
			if (cmd.valid && cmd.ready)
				track_command();
		end
	end

endmodule

// File: test/tb_ack_retransmit_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ack_retransmit_table
// Drives sends, acknowledges and resend scans into the retransmission table
// under several register settings and back-pressure mixes; the checker
// predicts every result word and reports the failures.
// ----------------------------------------------------------------------------
module tb_ack_retransmit_table;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic [31:0] clock_ms;
	logic [31:0] seq_seen;

	art_cmd_if cmd ();
	art_res_if res ();
	art_cfg_if cfg ();

	ack_retransmit_table DUT (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res), .cfg(cfg));
	art_checker u_checker (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res), .cfg(cfg),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(art_pkg::reg_idx_t idx, logic [15:0] value);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (3 * art_pkg::SLOTS + 10) @(negedge clk);
	endtask

	task automatic issue(art_pkg::action_t act, logic [31:0] now, logic [7:0] pid,
		logic [15:0] psize, logic [15:0] rlen, logic [15:0] hlen, logic [31:0] hseq);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 0;
			@(negedge clk);
		end
		cmd.valid <= 1; cmd.action <= act; cmd.now_ms <= now; cmd.ptype <= pid;
		cmd.body_len <= psize; cmd.received_len <= rlen;
		cmd.header_total_len <= hlen; cmd.header_seq <= hseq;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
	endtask

	task automatic idle_cmd();
		cmd.valid <= 0;
		@(negedge clk);
	endtask

	task automatic random_item();
		int          pick;
		logic [15:0] rl;
		pick = $urandom_range(99);
		clock_ms = clock_ms + $urandom_range(150);
		rl = 16'($urandom_range(7, 2000));
		if (pick < 40)
			issue(art_pkg::ACT_SEND, clock_ms, 8'($urandom),
				($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500)),
				16'($urandom), 16'($urandom), $urandom);
		else if (pick < 70)
			issue(art_pkg::ACT_RECV, clock_ms, 8'($urandom), 16'($urandom), rl,
				16'($urandom_range(7, rl)), seq_seen - $urandom_range(20));
		else if (pick < 90)
			issue(art_pkg::ACT_SCAN, clock_ms + $urandom_range(300), 8'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), $urandom);
		else if (pick < 97)
			issue(art_pkg::ACT_RECV, ($urandom_range(1) != 0) ? clock_ms : $urandom,
				8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
		else
			issue(art_pkg::ACT_NONE, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), $urandom);
		if (pick < 40) seq_seen = seq_seen + 32'd1;
	endtask

	initial begin
		arst_n = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		clock_ms = 0; seq_seen = 0;
		cmd.valid = 0; cmd.action = art_pkg::ACT_NONE; cmd.now_ms = 0; cmd.ptype = 0;
		cmd.body_len = 0; cmd.received_len = 0; cmd.header_total_len = 0;
		cmd.header_seq = 0;
		cfg.valid = 0; cfg.index = art_pkg::REG_LINK_UP; cfg.data = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// link down refusals, then extremes under reset settings
		issue(art_pkg::ACT_SEND, 32'd0, 8'hFF, 16'd10, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_RECV, 32'd0, 8'h00, 16'd0, 16'd100, 16'd50, 32'hFFFF_FFFF);
		issue(art_pkg::ACT_SCAN, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_NONE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF);
		idle_cmd(); settle();
		write_reg(art_pkg::REG_LINK_UP, 16'd1);
		issue(art_pkg::ACT_SEND, 32'hFFFF_FFF0, 8'hA5, 16'd1465, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_SEND, 32'hFFFF_FFF0, 8'h5A, 16'd1466, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_SEND, 32'hFFFF_FFF0, 8'h01, 16'hFFFF, 16'd0, 16'd0, 32'd0);
		for (int i = 0; i < 16; i++)
			issue(art_pkg::ACT_SEND, 32'hFFFF_FFF0, 8'(i), 16'(i), 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_RECV, 32'd0, 8'h11, 16'd0, 16'd6, 16'd6, 32'd0);
		issue(art_pkg::ACT_RECV, 32'd0, 8'h12, 16'd0, 16'd7, 16'd8, 32'd0);
		issue(art_pkg::ACT_RECV, 32'd0, 8'h13, 16'd0, 16'hFFFF, 16'hFFFF, 32'd1);
		issue(art_pkg::ACT_RECV, 32'd0, 8'h14, 16'd0, 16'd7, 16'd7, 32'd99999);
		issue(art_pkg::ACT_SCAN, 32'h0000_0100, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_SCAN, 32'h0000_0100, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		idle_cmd(); settle();
		seq_seen = 17;
		write_reg(art_pkg::REG_MAX_FRAME, 16'hFFFF);
		write_reg(art_pkg::REG_TIMEOUT, 16'hFFFF);
		write_reg(art_pkg::REG_MAX_RESENDS, 16'd255);
		issue(art_pkg::ACT_SEND, 32'd0, 8'h77, 16'hFFF8, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_SCAN, 32'h0002_0000, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		idle_cmd(); settle();
		write_reg(art_pkg::REG_MAX_FRAME, 16'd7);
		write_reg(art_pkg::REG_TIMEOUT, 16'd1);
		write_reg(art_pkg::REG_MAX_RESENDS, 16'd0);
		issue(art_pkg::ACT_SEND, 32'd0, 8'h33, 16'd0, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_SEND, 32'd0, 8'h34, 16'd1, 16'd0, 16'd0, 32'd0);
		issue(art_pkg::ACT_SCAN, 32'h0004_0000, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		idle_cmd(); settle();
		clock_ms = 32'h0004_0000;

		for (int phase = 0; phase < 6; phase++) begin
			case (phase % 3)
			0: begin send_idle_pct = 33; recv_stall_pct = 74; end
			1: begin send_idle_pct = 74; recv_stall_pct = 33; end
			default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			write_reg(art_pkg::REG_LINK_UP, (phase == 4) ? 16'd0 : 16'd1);
			write_reg(art_pkg::REG_MAX_FRAME,
				(phase == 3) ? 16'd7 : 16'($urandom_range(7, 1600)));
			write_reg(art_pkg::REG_TIMEOUT,
				(phase == 5) ? 16'd1 : 16'($urandom_range(1, 400)));
			write_reg(art_pkg::REG_MAX_RESENDS,
				(phase == 2) ? 16'd255 : 16'($urandom_range(0, 6)));
			for (int k = 0; k < 75; k++)
				random_item();
			idle_cmd(); settle();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/art_pkg.sv
rtl/art_if.sv
rtl/ack_retransmit_table.sv
rtl/art_chk.sv
test/art_checker.sv
test/tb_ack_retransmit_table.sv
